FILE: design/fbfla_pkg.sv
// ----------------------------------------------------------------------------
// Free-list allocator package
// Field widths, request and status codes, item types and parameter defaults
// shared by the allocator unit, its ring memory and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package fbfla_pkg;

  localparam int OP_W  = 2;
  localparam int REQ_W = 17;
  localparam int IDX_W = 6;
  localparam int ST_W  = 2;
  localparam int FC_W  = 7;

  localparam int NUM_BUFFERS_DEF  = 64;
  localparam int BUFFER_BYTES_DEF = 65536;
  localparam int HEADER_BYTES_DEF = 64;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [REQ_W-1:0] request_bytes;
    logic [IDX_W-1:0] free_index;
  } fbfla_in_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] granted_index;
    logic [FC_W-1:0]  free_count;
    logic             oversize_warn;
  } fbfla_out_t;

endpackage

`default_nettype wire

FILE: design/fbfla_ring.sv
// ----------------------------------------------------------------------------
// Free-list ring memory
// One write port and one read port; the read data is registered and holds
// its value until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfla_ring
  import fbfla_pkg::*;
#(
  parameter int DEPTH = NUM_BUFFERS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [IDX_W-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [IDX_W-1:0]         rd_data
);

  logic [IDX_W-1:0] mem [DEPTH];
  logic [IDX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: design/fixed_buffer_free_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// Fixed buffer free-list allocator unit
// Hands out and takes back numbers of equal fixed-size buffers through a FIFO
// ring of free buffer numbers, and reports the free count on every request.
// ----------------------------------------------------------------------------
// A request goes through the input register, then the result register.
// Throughput: one request per cycle unless out_stall holds the result;
// each takes at most one ring access and one pointer update.
// Reset: synchronous, active low; all buffers are free, highest number first.
// The ring needs no clearing pass: a saturating count of ring writes marks
// which entries still read as their reset contents.
`default_nettype none

module fixed_buffer_free_list_allocator_unit
  import fbfla_pkg::*;
#(
  parameter int NUM_BUFFERS  = NUM_BUFFERS_DEF,
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire fbfla_in_t  in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output fbfla_out_t      out_data
);

  // Pointer and count widths follow from the pool size; compare takes the wider.
  localparam int PTR_W = $clog2(NUM_BUFFERS);
  localparam int CNT_W = $clog2(NUM_BUFFERS + 1);
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int SUM_W = $clog2((2 ** REQ_W) + HEADER_BYTES + BUFFER_BYTES + 1);

  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(NUM_BUFFERS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_BUFFERS);
  localparam logic [CMP_W-1:0] NB_CMP   = CMP_W'(NUM_BUFFERS);
  localparam logic [SUM_W-1:0] HDR_SUM  = SUM_W'(HEADER_BYTES);
  localparam logic [SUM_W-1:0] BUF_SUM  = SUM_W'(BUFFER_BYTES);

  // Input register stage.
  logic      a_valid_r, a_valid_nxt;
  fbfla_in_t a_data_r;

  // Allocator state.
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] avail_r, avail_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  // Result register stage.
  logic             b_valid_r, b_valid_nxt;
  logic [ST_W-1:0]  b_status_r;
  logic             b_grant_r;
  logic             b_use_mem_r;
  logic [IDX_W-1:0] b_rst_val_r;
  logic [FC_W-1:0]  b_count_r;
  logic             b_warn_r;

  // Request decode.
  logic             a_load;
  logic             b_load;
  logic [ST_W-1:0]  status;
  logic             grant;
  logic             warn;
  logic             use_mem;
  logic [IDX_W-1:0] rst_val;
  logic             ring_wr_en;
  logic             ring_rd_en;
  logic [IDX_W-1:0] ring_rd_data;
  logic [SUM_W-1:0] req_sum;

  // The item in the input register moves on whenever the result register is
  // empty or its item is being taken; a new item enters whenever the input
  // register is empty or moving on. Stall on the output thus reaches the
  // input only when both registers are occupied.
  assign b_load   = a_valid_r & (~b_valid_r | ~out_stall);
  assign in_stall = a_valid_r & ~b_load;
  assign a_load   = in_valid & ~in_stall;

  assign a_valid_nxt = a_load | (a_valid_r & ~b_load);
  assign b_valid_nxt = b_load | (b_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_data_r <= in_data;
    end
  end

  // The oversize warning is raised on any oversize allocate, granted or not.
  assign req_sum = SUM_W'(a_data_r.request_bytes) + HDR_SUM;
  assign warn    = (a_data_r.op == OP_ALLOC) && (req_sum > BUF_SUM);

  // The ring is written strictly in order from entry zero, so an entry has
  // been written exactly when its number lies below the count of writes.
  // Entries not yet written read as the reset pattern instead, highest first.
  assign use_mem = CNT_W'(head_r) < fill_r;
  assign rst_val = IDX_W'(LAST_PTR - head_r);

  always_comb begin
    status     = ST_OK;
    grant      = 1'b0;
    ring_wr_en = 1'b0;
    ring_rd_en = 1'b0;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    avail_nxt  = avail_r;
    fill_nxt   = fill_r;
    case (a_data_r.op)
      OP_ALLOC: begin
        if (avail_r == '0) begin
          status = ST_EMPTY;
        end else begin
          grant      = 1'b1;
          ring_rd_en = b_load;
          head_nxt   = (head_r == LAST_PTR) ? '0 : head_r + 1'b1;
          avail_nxt  = avail_r - 1'b1;
        end
      end
      OP_FREE: begin
        if (CMP_W'(a_data_r.free_index) >= NB_CMP) begin
          status = ST_RANGE;
        end else if (avail_r == FULL_CNT) begin
          // A full list cannot take another number: treated as a double free.
          status = ST_FULL;
        end else begin
          ring_wr_en = b_load;
          tail_nxt   = (tail_r == LAST_PTR) ? '0 : tail_r + 1'b1;
          avail_nxt  = avail_r + 1'b1;
          fill_nxt   = (fill_r == FULL_CNT) ? fill_r : fill_r + 1'b1;
        end
      end
      default: begin
        // Query, and the unused code, change nothing.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      avail_r <= FULL_CNT;
      fill_r  <= '0;
    end else if (b_load) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      avail_r <= avail_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_status_r  <= status;
      b_grant_r   <= grant;
      b_use_mem_r <= use_mem;
      b_rst_val_r <= rst_val;
      b_count_r   <= FC_W'(avail_nxt);
      b_warn_r    <= warn;
    end
  end

  // The ring's read data register is loaded with the result register on a
  // granted allocate and holds while the result waits, so both stay aligned.
  fbfla_ring #(
    .DEPTH (NUM_BUFFERS)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_wr_en),
    .wr_addr (tail_r),
    .wr_data (a_data_r.free_index),
    .rd_en   (ring_rd_en),
    .rd_addr (head_r),
    .rd_data (ring_rd_data)
  );

  assign out_valid              = b_valid_r;
  assign out_data.status        = b_status_r;
  assign out_data.granted_index = b_grant_r ? (b_use_mem_r ? ring_rd_data : b_rst_val_r)
                                            : '0;
  assign out_data.free_count    = b_count_r;
  assign out_data.oversize_warn = b_warn_r;

endmodule

`default_nettype wire

FILE: design/fbfla_checker.sv
// ----------------------------------------------------------------------------
// Free-list allocator checker
// Watches the allocator's ports and checks reset, result hold and the
// consistency of status, granted number and free count.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfla_checker
  import fbfla_pkg::*;
#(
  parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire fbfla_out_t out_data
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or was dropped");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && (out_data.status == ST_EMPTY)
      |-> (out_data.free_count == '0) && (out_data.granted_index == '0))
    else $error("empty status with free buffers or a granted number");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && (out_data.status == ST_FULL)
      |-> out_data.free_count == FC_W'(NUM_BUFFERS))
    else $error("double free reported while the list is not full");

  a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && (out_data.status != ST_OK) |-> out_data.granted_index == '0)
    else $error("granted number on a failed request");

endmodule

bind fixed_buffer_free_list_allocator_unit fbfla_checker #(
  .NUM_BUFFERS (NUM_BUFFERS)
) u_fbfla_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
